// ===== design/sllws_pkg.sv =====
package sllws_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int NUM_WORKERS_DEF = 8;
   localparam int KEY_WIDTH_DEF   = 32;

   localparam int OPCODE_W = 2;
   localparam int SKEY_W   = 32;
   localparam int WORKER_W = 3;
   localparam int COUNT_W  = 31;
   localparam int STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SELECT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_SET      = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT    = 3'd0,
      ST_NEW    = 3'd1,
      ST_NONE   = 3'd2,
      ST_FULL   = 3'd3,
      ST_ABSENT = 3'd4,
      ST_SET    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic latch_req;
      logic scan_step;
      logic pick_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic                clear_last;
      logic                rd_hit;
      logic                rd_last;
      logic                pick_last;
      logic                out_free;
      logic [OPCODE_W-1:0] op;
   } stat_type;

endpackage

// ===== design/sticky_least_loaded_worker_select.sv =====
// Session-affinity table with least-loaded worker choice. Requests are handled one at
// a time. After reset the table is cleared one entry per cycle, during which req_ready
// stays low. A SET_COUNT request goes from idle straight to the finish state.
// SELECT and DELETE walk the table one entry per cycle from a single-port memory with a
// registered read: a hit ends the walk early, a miss reads every entry, and a SELECT
// miss then scans the worker counts one per cycle.
// The response register lets the result wait on rsp_ready without losing the request.
module sticky_least_loaded_worker_select
   import sllws_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int NUM_WORKERS = NUM_WORKERS_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [SKEY_W-1:0]   req_session_key,
   input  logic [WORKER_W-1:0] req_worker_index,
   input  logic [COUNT_W-1:0]  req_user_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORKER_W-1:0] rsp_chosen_worker,
   output logic                rsp_worker_valid,
   output logic [STATUS_W-1:0] rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   sllws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sllws_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUM_WORKERS (NUM_WORKERS),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_opcode),
      .req_session_key   (req_session_key),
      .req_worker_index  (req_worker_index),
      .req_user_count    (req_user_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chosen_worker (rsp_chosen_worker),
      .rsp_worker_valid  (rsp_worker_valid),
      .rsp_status        (rsp_status)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode != OP_RESERVED)) |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_unused_op_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_RESERVED) && !rsp_valid) |=> !rsp_valid)
      else $error("unused opcode produced a response");

   a_worker_valid_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_worker_valid) |-> (rsp_status == ST_HIT || rsp_status == ST_NEW))
      else $error("worker flagged valid with a failure status");

   a_set_no_worker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_SET)) |-> (!rsp_worker_valid && rsp_chosen_worker == '0))
      else $error("count set response carries a worker");

endmodule

// ===== design/sllws_ctrl.sv =====
module sllws_ctrl
   import sllws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   input  stat_type            stat,
   output cmd_type             cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_SELECT, OP_DELETE: state_in = S_SCAN;
                  OP_SET:               state_in = S_FINISH;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (stat.rd_hit) begin
               state_in = S_FINISH;
            end else if (stat.rd_last) begin
               state_in = (stat.op == OP_SELECT) ? S_PICK : S_FINISH;
            end
         end
         S_PICK: begin
            if (stat.pick_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == S_IDLE);
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.latch_req  = (state_ff == S_IDLE) && req_valid;
      cmd.scan_step  = (state_ff == S_SCAN);
      cmd.pick_step  = (state_ff == S_PICK);
      cmd.commit     = (state_ff == S_FINISH) && stat.out_free;
   end

endmodule

// ===== design/sllws_dp.sv =====
module sllws_dp
   import sllws_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int NUM_WORKERS = NUM_WORKERS_DEF,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [SKEY_W-1:0]   req_session_key,
   input  logic [WORKER_W-1:0] req_worker_index,
   input  logic [COUNT_W-1:0]  req_user_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORKER_W-1:0] rsp_chosen_worker,
   output logic                rsp_worker_valid,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
   localparam int EW = 1 + KEY_WIDTH + WORKER_W;
   localparam logic [AW:0]   DEPTH_C     = (AW+1)'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ENTRY  = AW'(TABLE_DEPTH - 1);
   localparam logic [WW-1:0] LAST_WORKER = WW'(NUM_WORKERS - 1);

   // session table: {valid, key, worker}
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;

   logic [COUNT_W-1:0]   load_ff [NUM_WORKERS];
   logic [NUM_WORKERS-1:0] known_ff;

   logic [OPCODE_W-1:0]  op_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [WORKER_W-1:0]  widx_ff;
   logic [COUNT_W-1:0]   cnt_ff;

   logic [AW-1:0] clr_ff, clr_in;
   logic [AW:0]   scan_addr_ff, scan_addr_in;
   logic [AW-1:0] rd_idx_ff;
   logic          rd_vld_ff, rd_vld_in;
   logic          issue;

   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff;
   logic [WORKER_W-1:0] hit_worker_ff;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff;

   logic [WW-1:0]      wcnt_ff, wcnt_in;
   logic               best_ff, best_in;
   logic [WW-1:0]      best_idx_ff;
   logic [COUNT_W-1:0] best_load_ff;
   logic               best_take;

   logic               rd_entry_valid;
   logic [KEY_WIDTH-1:0] rd_entry_key;
   logic               rd_hit;

   logic [WW-1:0]      dec_idx;
   logic               dec_ok;
   logic [WW-1:0]      set_idx;
   logic               set_ok;
   logic [WW-1:0]      ld_raddr;
   logic [COUNT_W-1:0] ld_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORKER_W-1:0] res_worker;
   logic               res_wvalid;
   status_type         res_status;
   logic               do_insert;
   logic               do_remove;

   // latch request
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= req_opcode;
         key_ff  <= KEY_WIDTH'(req_session_key);
         widx_ff <= req_worker_index;
         cnt_ff  <= req_user_count;
      end
   end

   // table scan
   assign issue          = scan_addr_ff < DEPTH_C;
   assign rd_entry_valid = rd_data_ff[EW-1];
   assign rd_entry_key   = rd_data_ff[EW-2:WORKER_W];
   assign rd_hit         = cmd.scan_step && rd_vld_ff && rd_entry_valid
                           && (rd_entry_key == key_ff);

   always_comb begin
      clr_in       = cmd.clear_step ? clr_ff + AW'(1) : clr_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = rd_vld_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      if (cmd.latch_req) begin
         scan_addr_in = '0;
         rd_vld_in    = 1'b0;
         hit_in       = 1'b0;
         free_in      = 1'b0;
      end else if (cmd.scan_step) begin
         scan_addr_in = issue ? scan_addr_ff + (AW+1)'(1) : scan_addr_ff;
         rd_vld_in    = issue;
         if (rd_hit) begin
            hit_in = 1'b1;
         end
         if (rd_vld_ff && !rd_entry_valid) begin
            free_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         scan_addr_ff <= scan_addr_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_step && issue) begin
         rd_data_ff <= mem[scan_addr_ff[AW-1:0]];
         rd_idx_ff  <= scan_addr_ff[AW-1:0];
      end
      if (rd_hit && !hit_ff) begin
         hit_idx_ff    <= rd_idx_ff;
         hit_worker_ff <= rd_data_ff[WORKER_W-1:0];
      end
      if (cmd.scan_step && rd_vld_ff && !rd_entry_valid && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // least-loaded worker search
   assign dec_idx  = WW'(hit_worker_ff);
   assign set_idx  = WW'(widx_ff);
   assign ld_raddr = cmd.pick_step ? wcnt_ff : dec_idx;
   assign ld_rdata = load_ff[ld_raddr];
   assign best_take = cmd.pick_step && known_ff[wcnt_ff]
                      && (!best_ff || (ld_rdata < best_load_ff));

   always_comb begin
      wcnt_in = wcnt_ff;
      best_in = best_ff;
      if (cmd.latch_req) begin
         wcnt_in = '0;
         best_in = 1'b0;
      end else if (cmd.pick_step) begin
         wcnt_in = wcnt_ff + WW'(1);
         if (best_take) begin
            best_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0;
         best_ff <= 1'b0;
      end else begin
         wcnt_ff <= wcnt_in;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (best_take) begin
         best_idx_ff  <= wcnt_ff;
         best_load_ff <= ld_rdata;
      end
   end

   // result and commit
   assign dec_ok = (32'(hit_worker_ff) < NUM_WORKERS) && known_ff[dec_idx]
                   && (ld_rdata != '0);
   assign set_ok = 32'(widx_ff) < NUM_WORKERS;

   always_comb begin
      res_worker = '0;
      res_wvalid = 1'b0;
      res_status = ST_SET;
      do_insert  = 1'b0;
      do_remove  = 1'b0;
      case (op_ff)
         OP_SELECT: begin
            if (hit_ff) begin
               res_worker = hit_worker_ff;
               res_wvalid = 1'b1;
               res_status = ST_HIT;
            end else if (!best_ff) begin
               res_status = ST_NONE;
            end else if (!free_ff) begin
               res_status = ST_FULL;
            end else begin
               res_worker = WORKER_W'(best_idx_ff);
               res_wvalid = 1'b1;
               res_status = ST_NEW;
               do_insert  = 1'b1;
            end
         end
         OP_DELETE: begin
            if (hit_ff) begin
               res_worker = hit_worker_ff;
               res_wvalid = 1'b1;
               res_status = ST_HIT;
               do_remove  = 1'b1;
            end else begin
               res_status = ST_ABSENT;
            end
         end
         default: res_status = ST_SET;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.commit && do_insert) begin
         mem_we    = 1'b1;
         mem_waddr = free_idx_ff;
         mem_wdata = {1'b1, key_ff, WORKER_W'(best_idx_ff)};
      end else if (cmd.commit && do_remove) begin
         mem_we    = 1'b1;
         mem_waddr = hit_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (cmd.commit && (op_ff == OP_SET) && set_ok) begin
         known_ff[set_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (op_ff == OP_SET) && set_ok) begin
         load_ff[set_idx] <= cnt_ff;
      end else if (cmd.commit && do_remove && dec_ok) begin
         load_ff[dec_idx] <= ld_rdata - COUNT_W'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_chosen_worker <= res_worker;
         rsp_worker_valid  <= res_wvalid;
         rsp_status        <= res_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.clear_last = (clr_ff == LAST_ENTRY);
      stat.rd_hit     = rd_hit;
      stat.rd_last    = rd_vld_ff && (rd_idx_ff == LAST_ENTRY);
      stat.pick_last  = (wcnt_ff == LAST_WORKER);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.op         = op_ff;
   end

endmodule
